// File: rtl/ps2mpt_pkg.sv
package ps2mpt_pkg;

   // Request kinds carried in req_tuser
   typedef enum logic {
      OP_DATA  = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   // Command kinds handed from the front to the back
   typedef enum logic {
      CMD_BYTE  = 1'b0,
      CMD_CLEAR = 1'b1
   } cmd_kind_type;

   // Packet assembly position, one-hot
   typedef enum logic [2:0] {
      POS_HEAD = 3'b001,
      POS_X    = 3'b010,
      POS_Y    = 3'b100
   } byte_pos_type;

   // Classified command in the queue
   typedef struct packed {
      cmd_kind_type kind;
      logic         sync;    // bit 3 of the byte, marks a valid header
      logic [7:0]   data;
   } cmd_type;

   // Header bit positions
   localparam int unsigned HDR_SYNC_BIT  = 3;
   localparam int unsigned HDR_XSIGN_BIT = 4;
   localparam int unsigned HDR_YSIGN_BIT = 5;
   localparam int unsigned BTN_LEFT      = 0;
   localparam int unsigned BTN_RIGHT     = 1;
   localparam int unsigned BTN_MIDDLE    = 2;

   // Queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   // Register map
   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam logic        CSR_IDX_WIDTH  = 1'b0;
   localparam logic        CSR_IDX_HEIGHT = 1'b1;
   localparam int unsigned SIZE_BITS = 13;
   localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = 13'd320;
   localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = 13'd200;

   // Cursor start position
   localparam int unsigned START_X = 160;
   localparam int unsigned START_Y = 100;

endpackage

// File: rtl/ps2mpt_front.sv
module ps2mpt_front
   import ps2mpt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tuser,
   output logic       cmd_valid,
   output cmd_type    cmd,
   input  logic       cmd_pop
);

   cmd_type    queue_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   cmd_type    new_cmd;

   // Classify the incoming request
   always_comb begin
      new_cmd.kind = (req_tuser == OP_CLEAR) ? CMD_CLEAR : CMD_BYTE;
      new_cmd.sync = req_tdata[HDR_SYNC_BIT];
      new_cmd.data = req_tdata;
   end

   assign req_tready = (count_ff != 2'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != 2'd0);
   assign cmd        = queue_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the classified command
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// File: rtl/ps2mpt_back.sv
module ps2mpt_back
   import ps2mpt_pkg::*;
#(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  cmd_type               cmd,
   output logic                  cmd_pop,
   input  logic [COORD_BITS-1:0] lim_x,
   input  logic [COORD_BITS-1:0] lim_y,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [COORD_BITS-1:0] cursor_x,
   output logic [COORD_BITS-1:0] cursor_y,
   output logic signed [8:0]     delta_x,
   output logic signed [9:0]     delta_y,
   output logic [2:0]            buttons,
   output logic [1:0]            clicks,
   output logic                  packet_done
);

   byte_pos_type          pos_ff, pos_in;
   logic [7:0]            header_ff, header_in;
   logic [7:0]            xbyte_ff, xbyte_in;
   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0] pos_y_ff, pos_y_in;
   logic signed [8:0]     dx_ff, dx_in;
   logic signed [9:0]     dy_ff, dy_in;
   logic [2:0]            btn_ff, btn_in;
   logic [1:0]            click_ff, click_in;
   logic                  done_ff, done_in;
   logic                  valid_ff, valid_in;
   logic signed [8:0]     dx_new;
   logic signed [9:0]     dy_raw;
   logic signed [9:0]     dy_new;
   logic [2:0]            btn_new;

   function automatic logic [COORD_BITS-1:0] clamp_move(
      input logic [COORD_BITS-1:0] pos,
      input logic signed [9:0]     delta,
      input logic [COORD_BITS-1:0] lim
   );
      logic signed [COORD_BITS+1:0] sum;
      logic [COORD_BITS-1:0]        res;
      sum = $signed({2'b00, pos}) + (COORD_BITS+2)'(delta);
      if (sum < 0) begin
         res = '0;
      end else if (sum > $signed({2'b00, lim})) begin
         res = lim;
      end else begin
         res = sum[COORD_BITS-1:0];
      end
      return res;
   endfunction

   // Take a command whenever the result slot is free or being drained
   assign cmd_pop = cmd_valid && (!valid_ff || rsp_tready);

   // Decode movement from the stored header and x byte and the incoming y byte
   assign dx_new  = {header_ff[HDR_XSIGN_BIT], xbyte_ff};
   assign dy_raw  = {header_ff[HDR_YSIGN_BIT], header_ff[HDR_YSIGN_BIT], cmd.data};
   assign dy_new  = -dy_raw;
   assign btn_new = header_ff[2:0];

   // Next tracked state
   always_comb begin
      pos_in    = pos_ff;
      header_in = header_ff;
      xbyte_in  = xbyte_ff;
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      btn_in    = btn_ff;
      click_in  = click_ff;
      done_in   = 1'b0;
      if (cmd.kind == CMD_CLEAR) begin
         dx_in    = '0;
         dy_in    = '0;
         click_in = '0;
      end else begin
         unique case (pos_ff)
            POS_X: begin
               xbyte_in = cmd.data;
               pos_in   = POS_Y;
            end
            POS_Y: begin
               dx_in    = dx_new;
               dy_in    = dy_new;
               btn_in   = btn_new;
               click_in = {!btn_ff[BTN_RIGHT] && btn_new[BTN_RIGHT],
                           !btn_ff[BTN_LEFT] && btn_new[BTN_LEFT]};
               pos_x_in = clamp_move(pos_x_ff, 10'(dx_new), lim_x);
               pos_y_in = clamp_move(pos_y_ff, dy_new, lim_y);
               pos_in   = POS_HEAD;
               done_in  = 1'b1;
            end
            default: begin
               // Header slot: drop bytes without the sync bit
               if (cmd.sync) begin
                  header_in = cmd.data;
                  pos_in    = POS_X;
               end else begin
                  pos_in = POS_HEAD;
               end
            end
         endcase
      end
   end

   // Result slot valid
   always_comb begin
      if (cmd_pop) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // Update state only when a command is taken; the state doubles as the result
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_HEAD;
         header_ff <= '0;
         xbyte_ff  <= '0;
         pos_x_ff  <= COORD_BITS'(START_X);
         pos_y_ff  <= COORD_BITS'(START_Y);
         dx_ff     <= '0;
         dy_ff     <= '0;
         btn_ff    <= '0;
         click_ff  <= '0;
         done_ff   <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (cmd_pop) begin
            pos_ff    <= pos_in;
            header_ff <= header_in;
            xbyte_ff  <= xbyte_in;
            pos_x_ff  <= pos_x_in;
            pos_y_ff  <= pos_y_in;
            dx_ff     <= dx_in;
            dy_ff     <= dy_in;
            btn_ff    <= btn_in;
            click_ff  <= click_in;
            done_ff   <= done_in;
         end
      end
   end

   assign rsp_tvalid  = valid_ff;
   assign cursor_x    = pos_x_ff;
   assign cursor_y    = pos_y_ff;
   assign delta_x     = dx_ff;
   assign delta_y     = dy_ff;
   assign buttons     = btn_ff;
   assign clicks      = click_ff;
   assign packet_done = done_ff;

endmodule

// File: rtl/ps2_mouse_packet_tracker.sv
// Channel   Direction  Handshake            Payload
// req_      in         tvalid/tready        tdata: data_byte; tuser: op
// rsp_      out        tvalid/tready        tdata: tracked state; tlast: packet_done
// csr_      in         psel/penable/pwrite  column count @0x0, row count @0x4
//
// One request per cycle while the queue has room, one result per request;
// a result is offered once its request has passed the front queue and then
// the back state register. Each packet moves the cursor by one add and clamp.
// A two-entry queue lets requests keep coming while rsp_ stalls.
// Synchronous active-high reset; screen size returns to 320 x 200.
module ps2_mouse_packet_tracker
   import ps2mpt_pkg::*;
#(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [7:0] data_byte
   input  logic                     req_tuser,   // [0] op
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // cursor_x, cursor_y, delta_x, delta_y, button_left, button_right,
   // button_middle, left_click, right_click (lowest bit first)
   output logic [((2*COORD_BITS+24+7)/8)*8-1:0] rsp_tdata,
   output logic                     rsp_tlast,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   localparam int unsigned RSP_W = ((2*COORD_BITS+24+7)/8)*8;

   logic [SIZE_BITS-1:0]  width_ff, height_ff;
   logic [COORD_BITS-1:0] lim_x_ff, lim_y_ff;
   logic                  csr_write;
   logic                  csr_idx;
   logic                  cmd_valid;
   cmd_type               cmd;
   logic                  cmd_pop;
   logic [COORD_BITS-1:0] cursor_x, cursor_y;
   logic signed [8:0]     delta_x;
   logic signed [9:0]     delta_y;
   logic [2:0]            buttons;
   logic [1:0]            clicks;
   logic                  packet_done;

   // Largest coordinate for a screen size: zero acts as one, big sizes saturate
   function automatic logic [COORD_BITS-1:0] size_limit(input logic [SIZE_BITS-1:0] size);
      logic [COORD_BITS-1:0] lim;
      if (size == '0) begin
         lim = '0;
      end else if (32'(size) > (32'd1 << COORD_BITS)) begin
         lim = '1;
      end else begin
         lim = COORD_BITS'(size - SIZE_BITS'(1));
      end
      return lim;
   endfunction

   // Register writes and reads
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[2];
   assign csr_prdata = (csr_idx == CSR_IDX_HEIGHT) ? 32'(height_ff) : 32'(width_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         lim_x_ff  <= size_limit(RESET_WIDTH);
         lim_y_ff  <= size_limit(RESET_HEIGHT);
      end else if (csr_write) begin
         if (csr_idx == CSR_IDX_WIDTH) begin
            width_ff <= csr_pwdata[SIZE_BITS-1:0];
            lim_x_ff <= size_limit(csr_pwdata[SIZE_BITS-1:0]);
         end else begin
            height_ff <= csr_pwdata[SIZE_BITS-1:0];
            lim_y_ff  <= size_limit(csr_pwdata[SIZE_BITS-1:0]);
         end
      end
   end

   ps2mpt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   ps2mpt_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .lim_x       (lim_x_ff),
      .lim_y       (lim_y_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .cursor_x    (cursor_x),
      .cursor_y    (cursor_y),
      .delta_x     (delta_x),
      .delta_y     (delta_y),
      .buttons     (buttons),
      .clicks      (clicks),
      .packet_done (packet_done)
   );

   // Pack the result
   assign rsp_tdata = RSP_W'({clicks[BTN_RIGHT], clicks[BTN_LEFT], buttons[BTN_MIDDLE],
                              buttons[BTN_RIGHT], buttons[BTN_LEFT], delta_y, delta_x,
                              cursor_y, cursor_x});
   assign rsp_tlast = packet_done;

   // A click flag is only ever set while its button is held
   a_click_needs_button: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(clicks[BTN_LEFT] && !buttons[BTN_LEFT]) &&
                     !(clicks[BTN_RIGHT] && !buttons[BTN_RIGHT]))
      else $error("click flag without held button");

   // A full queue always has a command to offer the back
   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> cmd_valid)
      else $error("queue full but empty");

   // A clear taken by the back yields zeroed movement and clicks next cycle
   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      cmd_pop && cmd.kind == CMD_CLEAR |=> rsp_tvalid && delta_x == '0 &&
         delta_y == '0 && clicks == '0 && !packet_done)
      else $error("clear did not zero frame state");

endmodule
